/* rtl/bbds_pkg.sv */
// Shared types and constants for the box blur detail sharpen unit.
// No dependencies; the top level, the front and back parts and the testbench import it.
package bbds_pkg;

  // Line store depth (pixels per row at most)
  localparam int unsigned MAX_WIDTH = 1024;
  // Rows per image at most, and the row counter width (counts up to one past the last row)
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned ROW_W      = 13;

  localparam int unsigned PIX_W  = 24;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SUM_W  = 12;

  // Configuration port
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CFG_WIDTH_BITS = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam int unsigned DIM_MIN            = 3;
  localparam int unsigned IMAGE_WIDTH_RESET  = 640;
  localparam int unsigned IMAGE_HEIGHT_RESET = 480;

  // Item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Divide by nine: floor(s * 7282 / 2^16) equals floor(s / 9) for s below 2^12
  localparam int unsigned DIV9_RECIP   = 7282;
  localparam int unsigned DIV9_RECIP_W = 13;
  localparam int unsigned DIV9_SHIFT   = 16;

  // Per-item decisions made by the front part
  typedef struct packed {
    logic emit;    // item releases an output pixel
    logic border;  // that pixel passes through unchanged
    logic last;    // that pixel closes the image
  } cmd_flags_t;

endpackage

/* rtl/box_blur_detail_sharpen_unit.sv */
// Streaming 3x3 box blur sharpening filter for RGB pixels in raster order.
// Takes one item per clock and gives one result per clock while both sides flow; the
// single line store RAM (one read and one write per item) sets that figure. The item
// releasing a result passes the queue, stages B to E and the output register; results
// trail pixels by one row plus one pixel, so image_width + 1 drain items close an image.
// The line store has no clearing pass: the block takes items straight after reset.
// Depends on bbds_pkg, bbds_front, bbds_queue, bbds_back and bbds_ram.
module box_blur_detail_sharpen_unit #(
  parameter int unsigned MaxWidth = bbds_pkg::MAX_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bbds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [bbds_pkg::CHAN_W-1:0]     red_in_i,
  input  logic [bbds_pkg::CHAN_W-1:0]     green_in_i,
  input  logic [bbds_pkg::CHAN_W-1:0]     blue_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bbds_pkg::CHAN_W-1:0]     red_out_o,
  output logic [bbds_pkg::CHAN_W-1:0]     green_out_o,
  output logic [bbds_pkg::CHAN_W-1:0]     blue_out_o,
  output logic                            end_of_image_o
);
  import bbds_pkg::*;

  localparam int unsigned ColW   = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned FlagsW = $bits(cmd_flags_t);
  localparam int unsigned CmdW   = ColW + PIX_W + FlagsW;

  logic             fr_valid, fr_ready;
  logic [ColW-1:0]  fr_col;
  logic [PIX_W-1:0] fr_pixel;
  cmd_flags_t       fr_flags;

  logic             bk_valid, bk_ready;
  logic [CmdW-1:0]  bk_data;
  cmd_flags_t       bk_flags;

  bbds_front #(
    .MaxWidth (MaxWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_col_o   (fr_col),
    .cmd_pixel_o (fr_pixel),
    .cmd_flags_o (fr_flags)
  );

  bbds_queue #(
    .DataW (CmdW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  ({fr_col, fr_pixel, fr_flags}),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_data)
  );

  assign bk_flags = cmd_flags_t'(bk_data[FlagsW-1:0]);

  bbds_back #(
    .MaxWidth (MaxWidth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (bk_valid),
    .cmd_ready_o    (bk_ready),
    .cmd_col_i      (bk_data[CmdW-1 -: ColW]),
    .cmd_pixel_i    (bk_data[FlagsW +: PIX_W]),
    .cmd_flags_i    (bk_flags),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .end_of_image_o (end_of_image_o)
  );

endmodule

/* rtl/bbds_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bbds_ram #(
  parameter int unsigned DataW = 48,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bbds_queue.sv */
// Two-entry transaction queue between the front and back parts.
// No dependencies.
module bbds_queue #(
  parameter int unsigned DataW = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [DataW-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [DataW-1:0] pop_data_o
);

  logic [DataW-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/bbds_front.sv */
// Front part: configuration registers, position counters and item classification.
// Depends on bbds_pkg.
module bbds_front #(
  parameter int unsigned MaxWidth = bbds_pkg::MAX_WIDTH,
  localparam int unsigned ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bbds_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bbds_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [bbds_pkg::CHAN_W-1:0]         red_in_i,
  input  logic [bbds_pkg::CHAN_W-1:0]         green_in_i,
  input  logic [bbds_pkg::CHAN_W-1:0]         blue_in_i,
  output logic                                cmd_valid_o,
  input  logic                                cmd_ready_i,
  output logic [ColW-1:0]                     cmd_col_o,
  output logic [bbds_pkg::PIX_W-1:0]          cmd_pixel_o,
  output bbds_pkg::cmd_flags_t                cmd_flags_o
);
  import bbds_pkg::*;

  localparam int unsigned WidW     = $clog2(MaxWidth + 1);
  localparam int unsigned CmpW     = (WidW > CFG_WIDTH_BITS) ? WidW : CFG_WIDTH_BITS;
  localparam int unsigned RstWidth =
      (IMAGE_WIDTH_RESET > MaxWidth) ? MaxWidth : IMAGE_WIDTH_RESET;

  logic [WidW-1:0]  width_q, width_d;
  logic [ROW_W-1:0] height_q, height_d;
  logic [ColW-1:0]  in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [ColW-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;

  logic [CmpW-1:0]  wr_width, clamp_width;
  logic [ROW_W-1:0] wr_height;
  logic             ignore, step, emit, in_col_wrap, out_col_wrap;
  logic             out_last_row, out_last_col;

  // Configuration: clamp to the supported range
  assign wr_width  = CmpW'(cfg_data_i[CFG_WIDTH_BITS-1:0]);
  assign wr_height = cfg_data_i[ROW_W-1:0];

  always_comb begin
    priority if (wr_width < CmpW'(DIM_MIN)) begin
      clamp_width = CmpW'(DIM_MIN);
    end else if (wr_width > CmpW'(MaxWidth)) begin
      clamp_width = CmpW'(MaxWidth);
    end else begin
      clamp_width = wr_width;
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH: begin
          width_d = WidW'(clamp_width);
        end
        CFG_IMAGE_HEIGHT: begin
          priority if (wr_height < ROW_W'(DIM_MIN)) begin
            height_d = ROW_W'(DIM_MIN);
          end else if (wr_height > ROW_W'(MAX_HEIGHT)) begin
            height_d = ROW_W'(MAX_HEIGHT);
          end else begin
            height_d = wr_height;
          end
        end
        default: begin
          width_d = width_q;
        end
      endcase
    end
  end

  // Classification
  assign ignore       = (operation_i == OP_DRAIN) && (in_row_q < height_q);
  assign emit         = (in_row_q >= ROW_W'(2)) ||
                        ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
  assign in_col_wrap  = (WidW'(in_col_q) + WidW'(1)) >= width_q;
  assign out_col_wrap = (WidW'(out_col_q) + WidW'(1)) >= width_q;
  assign out_last_col = out_col_wrap;
  assign out_last_row = (out_row_q + ROW_W'(1)) >= height_q;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i && !ignore;
  assign step        = in_valid_i && cmd_ready_i && !ignore;

  assign cmd_col_o   = in_col_q;
  assign cmd_pixel_o = (operation_i == OP_DRAIN) ? '0 : {blue_in_i, green_in_i, red_in_i};

  // First column of a row releases the right border pixel of an earlier row
  assign cmd_flags_o.emit   = emit;
  assign cmd_flags_o.border = (in_col_q == '0) || (out_row_q == '0) || out_last_row ||
                              (out_col_q == '0) || out_last_col;
  assign cmd_flags_o.last   = out_last_row && out_last_col;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_we_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (step) begin
      if (in_col_wrap) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + ColW'(1);
      end
      if (emit) begin
        if (out_last_row && out_last_col) begin
          // image closed: restart every position
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_wrap) begin
          out_col_d = '0;
          out_row_d = out_row_q + ROW_W'(1);
        end else begin
          out_col_d = out_col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WidW'(RstWidth);
      height_q  <= ROW_W'(IMAGE_HEIGHT_RESET);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

/* rtl/bbds_back.sv */
// Back part: line store, 3x3 window, mean, detail and saturation, output register.
// Depends on bbds_pkg and bbds_ram.
module bbds_back #(
  parameter int unsigned MaxWidth = bbds_pkg::MAX_WIDTH,
  localparam int unsigned ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  logic [ColW-1:0]             cmd_col_i,
  input  logic [bbds_pkg::PIX_W-1:0]  cmd_pixel_i,
  input  bbds_pkg::cmd_flags_t        cmd_flags_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bbds_pkg::CHAN_W-1:0] red_out_o,
  output logic [bbds_pkg::CHAN_W-1:0] green_out_o,
  output logic [bbds_pkg::CHAN_W-1:0] blue_out_o,
  output logic                        end_of_image_o
);
  import bbds_pkg::*;

  localparam int unsigned LineW = 2 * PIX_W;
  localparam int unsigned ProdW = SUM_W + DIV9_RECIP_W;

  logic advance, pop, wr_en;

  // Stage B: line data arrives
  logic             b_valid_q;
  logic [ColW-1:0]  b_col_q;
  logic [PIX_W-1:0] b_pix_q;
  cmd_flags_t       b_flags_q;
  logic             fwd_hit_q;
  logic [LineW-1:0] fwd_data_q;
  logic [LineW-1:0] ram_rdata, line_data, wr_data;

  // Window rows: older line, newer line, incoming; columns oldest to newest
  logic [2:0][2:0][PIX_W-1:0] win_q;

  // Stage C: window in place
  logic       c_valid_q;
  cmd_flags_t c_flags_q;
  logic [2:0][SUM_W-1:0] c_sum;

  // Stage D: channel sums
  logic                  d_valid_q;
  cmd_flags_t            d_flags_q;
  logic [2:0][SUM_W-1:0] d_sum_q;
  logic [PIX_W-1:0]      d_center_q;
  logic [2:0][ProdW-1:0] d_prod;

  // Stage E: channel means
  logic                   e_valid_q;
  cmd_flags_t             e_flags_q;
  logic [2:0][CHAN_W-1:0] e_mean_q;
  logic [PIX_W-1:0]       e_center_q;
  logic [PIX_W-1:0]       e_result;

  // Output register
  logic             out_valid_q;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_last_q;

  // Whole pipeline moves as one; the output register frees it
  assign advance     = !out_valid_q || out_ready_i;
  assign cmd_ready_o = advance;
  assign pop         = advance && cmd_valid_i;
  assign wr_en       = advance && b_valid_q;

  // Each column holds {older, newer}; newer moves down to older, incoming becomes newer
  assign line_data = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign wr_data   = {line_data[PIX_W-1:0], b_pix_q};

  bbds_ram #(
    .DataW (LineW),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (b_col_q),
    .wdata_i (wr_data),
    .re_i    (pop),
    .raddr_i (cmd_col_i),
    .rdata_o (ram_rdata)
  );

  // Stage B control and forwarding of a write to the column just read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= pop;
      if (pop) begin
        fwd_hit_q <= wr_en && (b_col_q == cmd_col_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_col_q    <= cmd_col_i;
      b_pix_q    <= cmd_pixel_i;
      b_flags_q  <= cmd_flags_i;
      fwd_data_q <= wr_data;
    end
  end

  // Shift the window by one column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (wr_en) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= line_data[LineW-1:PIX_W];
      win_q[1][2] <= line_data[PIX_W-1:0];
      win_q[2][2] <= b_pix_q;
    end
  end

  // Channel sums over the window
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_sum[k] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          c_sum[k] = c_sum[k] + SUM_W'(win_q[r][c][k*CHAN_W +: CHAN_W]);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_prod[k] = ProdW'(d_sum_q[k]) * ProdW'(DIV9_RECIP);
    end
  end

  // Detail and saturation; border pixels pass through unchanged
  always_comb begin
    logic [CHAN_W-1:0] orig, det;
    logic [CHAN_W:0]   boosted;
    for (int k = 0; k < 3; k++) begin
      orig = e_center_q[k*CHAN_W +: CHAN_W];
      det  = (orig > e_mean_q[k]) ? (orig - e_mean_q[k]) : (e_mean_q[k] - orig);
      boosted = {1'b0, orig} + {1'b0, det};
      e_result[k*CHAN_W +: CHAN_W] = boosted[CHAN_W] ? '1 : boosted[CHAN_W-1:0];
    end
    if (e_flags_q.border) begin
      e_result = e_center_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      c_valid_q   <= b_valid_q;
      d_valid_q   <= c_valid_q;
      e_valid_q   <= d_valid_q;
      out_valid_q <= e_valid_q && e_flags_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      c_flags_q  <= b_flags_q;
      d_flags_q  <= c_flags_q;
      d_sum_q    <= c_sum;
      d_center_q <= win_q[1][1];
      e_flags_q  <= d_flags_q;
      e_center_q <= d_center_q;
      for (int k = 0; k < 3; k++) begin
        e_mean_q[k] <= d_prod[k][DIV9_SHIFT +: CHAN_W];
      end
      out_pix_q  <= e_result;
      out_last_q <= e_flags_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_out_o      = out_pix_q[0 +: CHAN_W];
  assign green_out_o    = out_pix_q[CHAN_W +: CHAN_W];
  assign blue_out_o     = out_pix_q[2*CHAN_W +: CHAN_W];
  assign end_of_image_o = out_last_q;

endmodule

/* tb/tb_box_blur_detail_sharpen_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for box_blur_detail_sharpen_unit: predicts each sharpened pixel
// and compares it with the unit's output. Depends on bbds_pkg and the unit's RTL.
module tb_box_blur_detail_sharpen_unit;
  import bbds_pkg::*;

  localparam int unsigned BOX_TAPS          = 9;
  localparam int unsigned CHAN_MAX          = 255;
  localparam int unsigned SETTLE_CYCLES     = 20;
  localparam int unsigned LONG_STALL_CYCLES = 300;
  localparam int unsigned PHASE_GOAL        = 100;
  localparam int unsigned RUN_LIMIT_NS      = 4_000_000;

  // index 0 red, 1 green, 2 blue
  typedef logic [2:0][CHAN_W-1:0] rgb_t;

  typedef struct packed {
    logic op;
    rgb_t pix;
  } pixel_item_t;

  typedef struct packed {
    rgb_t pix;
    logic eoi;
  } sharp_pixel_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic                  operation_i = OP_PIXEL;
  logic [CHAN_W-1:0]     red_in_i    = '0;
  logic [CHAN_W-1:0]     green_in_i  = '0;
  logic [CHAN_W-1:0]     blue_in_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CHAN_W-1:0]     red_out_o;
  logic [CHAN_W-1:0]     green_out_o;
  logic [CHAN_W-1:0]     blue_out_o;
  logic                  end_of_image_o;

  pixel_item_t  pixel_feed [$];
  sharp_pixel_t sharpened_due [$];

  int unsigned send_idle_pct       = 0;
  int unsigned recv_stall_pct      = 0;
  int unsigned long_stall_requests = 0;
  int unsigned long_stall_served   = 0;
  int unsigned stall_left          = 0;
  int unsigned pixels_queued       = 0;
  int unsigned fault_count         = 0;

  // Filter state as the unit should hold it
  rgb_t        older_row [MAX_WIDTH];
  rgb_t        newer_row [MAX_WIDTH];
  rgb_t        window_px [BOX_TAPS];
  int unsigned in_col, in_row, out_col, out_row;
  int unsigned width_used  = IMAGE_WIDTH_RESET;
  int unsigned height_used = IMAGE_HEIGHT_RESET;

  box_blur_detail_sharpen_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .end_of_image_o (end_of_image_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned hi);
    if (raw < DIM_MIN) return DIM_MIN;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic void restart_positions();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // Advance the filter state by one accepted transaction and queue the pixel it releases
  task automatic sharpen_accepted(input logic op, input rgb_t pix);
    int unsigned col, sum, mean, centre, detail, boosted, k, ch;
    rgb_t        incoming, prev_mid, result;
    bit          emit, border, last;
    if (op == OP_DRAIN && in_row < height_used) return;
    incoming = (op == OP_DRAIN) ? '0 : pix;
    col      = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
    prev_mid = window_px[5];
    for (k = 0; k < 3; k++) begin
      window_px[k * 3]     = window_px[k * 3 + 1];
      window_px[k * 3 + 1] = window_px[k * 3 + 2];
    end
    window_px[2]   = older_row[col];
    window_px[5]   = newer_row[col];
    window_px[8]   = incoming;
    older_row[col] = newer_row[col];
    newer_row[col] = incoming;

    emit   = in_row >= 2 || (in_row == 1 && in_col >= 1);
    result = '0;
    if (emit) begin
      if (in_col == 0) begin
        // start of a row releases the right edge of the row before last
        result = prev_mid;
      end else begin
        border = out_row == 0 || out_row + 1 >= height_used
              || out_col == 0 || out_col + 1 >= width_used;
        if (border) begin
          result = window_px[4];
        end else begin
          for (ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (k = 0; k < BOX_TAPS; k++) sum += window_px[k][ch];
            mean    = sum / BOX_TAPS;
            centre  = window_px[4][ch];
            detail  = (centre > mean) ? centre - mean : mean - centre;
            boosted = centre + detail;
            if (boosted > CHAN_MAX) boosted = CHAN_MAX;
            result[ch] = boosted[CHAN_W-1:0];
          end
        end
      end
    end

    in_col++;
    if (in_col >= width_used) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;

    last = out_row + 1 >= height_used && out_col + 1 >= width_used;
    sharpened_due.push_back('{result, last});
    if (last) begin
      restart_positions();
    end else begin
      out_col++;
      if (out_col >= width_used) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      fault_count++;
    end
  endfunction

  function automatic rgb_t random_pixel();
    rgb_t        p;
    int unsigned ch;
    for (ch = 0; ch < 3; ch++) begin
      case ($urandom_range(9))
        0:       p[ch] = '0;
        1:       p[ch] = '1;
        default: p[ch] = CHAN_W'($urandom);
      endcase
    end
    return p;
  endfunction

  function automatic rgb_t mk_rgb(input int unsigned r, input int unsigned g,
                                  input int unsigned b);
    return {b[CHAN_W-1:0], g[CHAN_W-1:0], r[CHAN_W-1:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : send_side
    pixel_item_t next_item;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= OP_PIXEL;
      red_in_i    <= '0;
      green_in_i  <= '0;
      blue_in_i   <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        sharpen_accepted(operation_i, {blue_in_i, green_in_i, red_in_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item   = pixel_feed.pop_front();
          in_valid_i  <= 1'b1;
          operation_i <= next_item.op;
          red_in_i    <= next_item.pix[0];
          green_in_i  <= next_item.pix[1];
          blue_in_i   <= next_item.pix[2];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : receive_side
    sharp_pixel_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (sharpened_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual r=%0d g=%0d b=%0d eoi=%0b",
                   $time, red_out_o, green_out_o, blue_out_o, end_of_image_o);
          fault_count++;
        end else begin
          want = sharpened_due.pop_front();
          compare_field("red_out", want.pix[0], red_out_o);
          compare_field("green_out", want.pix[1], green_out_o);
          compare_field("blue_out", want.pix[2], blue_out_o);
          compare_field("end_of_image", want.eoi, end_of_image_o);
        end
      end
      if (long_stall_requests != long_stall_served) begin
        long_stall_served++;
        stall_left = LONG_STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Hold until nothing is pending or expected, then let the pipeline settle
  task automatic wait_all_results();
    @(negedge clk_i);
    while (pixel_feed.size() != 0 || in_valid_i || sharpened_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) begin
      width_used = clamp_dim(value[CFG_WIDTH_BITS-1:0], MAX_WIDTH);
    end else begin
      height_used = clamp_dim(value, MAX_HEIGHT);
    end
    restart_positions();
  endtask

  task automatic set_dims(input logic [CFG_DATA_W-1:0] w_raw,
                          input logic [CFG_DATA_W-1:0] h_raw);
    wait_all_results();
    write_register(CFG_IMAGE_WIDTH, w_raw);
    write_register(CFG_IMAGE_HEIGHT, h_raw);
  endtask

  // Queue stop_at pixels of a w x h image; a complete image gets its w + 1 flush items
  task automatic feed_image(input int unsigned w, input int unsigned h,
                            input int unsigned stop_at, input bit pause_midway);
    int unsigned n;
    @(negedge clk_i);
    for (n = 0; n < stop_at; n++) begin
      if (pause_midway && n == stop_at / 2) wait_all_results();
      pixel_feed.push_back('{OP_PIXEL, random_pixel()});
      // stray drain inside the image: must be dropped
      if (n + 1 < w * h && $urandom_range(99) < 3) begin
        pixel_feed.push_back('{OP_DRAIN, random_pixel()});
      end
    end
    pixels_queued += stop_at;
    if (stop_at == w * h) begin
      // a pixel past the image flushes just like a drain
      for (n = 0; n <= w; n++) begin
        pixel_feed.push_back('{($urandom_range(4) == 0) ? OP_PIXEL : OP_DRAIN,
                               random_pixel()});
      end
      pixels_queued += w + 1;
    end
  endtask

  task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned start, images, n, total, stop_at;
    logic [CFG_DATA_W-1:0] w_raw, h_raw;
    wait_all_results();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = pixels_queued;
    while (pixels_queued - start < PHASE_GOAL) begin
      case ($urandom_range(19))
        0:                        w_raw = CFG_DATA_W'($urandom_range(2));
        1, 2, 3, 4, 5:            w_raw = CFG_DATA_W'($urandom_range(40, 13));
        default:                  w_raw = CFG_DATA_W'($urandom_range(12, 3));
      endcase
      h_raw = ($urandom_range(19) == 0) ? CFG_DATA_W'($urandom_range(2))
                                        : CFG_DATA_W'($urandom_range(8, 3));
      set_dims(w_raw, h_raw);
      images = $urandom_range(3, 1);
      for (n = 0; n < images; n++) begin
        total   = width_used * height_used;
        // abandon only the last image of a setting; the next write restarts positions
        stop_at = (n + 1 == images && $urandom_range(9) == 0) ? $urandom_range(total - 1, 1)
                                                              : total;
        feed_image(width_used, height_used, stop_at,
                   pixels_queued == start || $urandom_range(5) == 0);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned i;
    for (i = 0; i < MAX_WIDTH; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (i = 0; i < BOX_TAPS; i++) window_px[i] = '0;
    restart_positions();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Smallest image with extreme values around a single interior pixel
    set_dims(CFG_DATA_W'(0), CFG_DATA_W'(2));
    @(negedge clk_i);
    pixel_feed.push_back('{OP_DRAIN, mk_rgb(255, 255, 255)});
    for (i = 0; i < 9; i++) begin
      pixel_feed.push_back('{OP_PIXEL, (i == 4) ? mk_rgb(255, 0, 100) : mk_rgb(0, 255, 100)});
    end
    for (i = 0; i < 3; i++) pixel_feed.push_back('{OP_DRAIN, mk_rgb(0, 0, 0)});
    pixel_feed.push_back('{OP_PIXEL, mk_rgb(255, 255, 255)});
    pixel_feed.push_back('{OP_DRAIN, mk_rgb(0, 0, 0)});

    // Largest sizes: a wide image cut short after its first outputs, then a tall one
    // cut short while the receiver holds off
    set_dims(CFG_DATA_W'(2047), CFG_DATA_W'(MAX_HEIGHT));
    feed_image(width_used, height_used, width_used + 20, 1'b0);
    set_dims(13'h1803, 13'h1fff);
    long_stall_requests++;
    feed_image(width_used, height_used, 120, 1'b0);

    run_random_phase(0, 0);
    run_random_phase(77, 0);
    run_random_phase(0, 77);
    run_random_phase(20, 20);

    wait_all_results();
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("timeout at %0t with %0d results outstanding", $time, sharpened_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
